>>> rtl/rttfc_pkg.sv
// Package for the round-trip-time flow control block.
// Holds register codes, reset values and the structs shared by the modules.
// Depends on nothing.
package rttfc_pkg;

  // Field widths
  localparam int unsigned TimeW = 16;
  localparam int unsigned RateW = 8;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned OutW  = 32;

  // Register indexes (byte address is four times the index)
  localparam logic [2:0] REG_RTT_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_START_PENALTY = 3'd1;
  localparam logic [2:0] REG_MIN_PENALTY   = 3'd2;
  localparam logic [2:0] REG_MAX_PENALTY   = 3'd3;
  localparam logic [2:0] REG_STABLE        = 3'd4;
  localparam logic [2:0] REG_GOOD_RATE     = 3'd5;
  localparam logic [2:0] REG_BAD_RATE      = 3'd6;

  // Register reset values
  localparam logic [TimeW-1:0] RST_RTT_THRESHOLD = 16'd250;
  localparam logic [TimeW-1:0] RST_START_PENALTY = 16'd120;
  localparam logic [TimeW-1:0] RST_MIN_PENALTY   = 16'd30;
  localparam logic [TimeW-1:0] RST_MAX_PENALTY   = 16'd1800;
  localparam logic [TimeW-1:0] RST_STABLE        = 16'd300;
  localparam logic [RateW-1:0] RST_GOOD_RATE     = 8'd30;
  localparam logic [RateW-1:0] RST_BAD_RATE      = 8'd10;

  // Input kind codes
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  // Configuration as seen by the core
  typedef struct packed {
    logic [TimeW-1:0] rtt_threshold_ms;
    logic [TimeW-1:0] start_penalty_ticks;
    logic [TimeW-1:0] min_penalty_ticks;
    logic [TimeW-1:0] max_penalty_ticks;
    logic [TimeW-1:0] stable_ticks;
    logic [RateW-1:0] good_send_rate;
    logic [RateW-1:0] bad_send_rate;
  } cfg_t;

  // One result word, packed in port order from the lowest bit
  typedef struct packed {
    logic             mode_changed;
    logic [TimeW-1:0] penalty_now;
    logic [RateW-1:0] send_rate;
    logic             good_mode;
  } res_t;

  // Saturating timer increment
  function automatic logic [TimeW-1:0] sat_inc(input logic [TimeW-1:0] v);
    sat_inc = (v == {TimeW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

>>> rtl/rttfc_regs.sv
// Configuration register file behind an APB-style port.
// Depends on rttfc_pkg for register codes, reset values and cfg_t.
module rttfc_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rttfc_pkg::AddrW-1:0] paddr,
  input  logic [rttfc_pkg::DataW-1:0] pwdata,
  output logic [rttfc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output rttfc_pkg::cfg_t           cfg
);
  import rttfc_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rtt_threshold_ms    <= RST_RTT_THRESHOLD;
      cfg.start_penalty_ticks <= RST_START_PENALTY;
      cfg.min_penalty_ticks   <= RST_MIN_PENALTY;
      cfg.max_penalty_ticks   <= RST_MAX_PENALTY;
      cfg.stable_ticks        <= RST_STABLE;
      cfg.good_send_rate      <= RST_GOOD_RATE;
      cfg.bad_send_rate       <= RST_BAD_RATE;
    end else if (wr_en) begin
      case (idx)
        REG_RTT_THRESHOLD: cfg.rtt_threshold_ms    <= pwdata[TimeW-1:0];
        REG_START_PENALTY: cfg.start_penalty_ticks <= pwdata[TimeW-1:0];
        REG_MIN_PENALTY:   cfg.min_penalty_ticks   <= pwdata[TimeW-1:0];
        REG_MAX_PENALTY:   cfg.max_penalty_ticks   <= pwdata[TimeW-1:0];
        REG_STABLE:        cfg.stable_ticks        <= pwdata[TimeW-1:0];
        REG_GOOD_RATE:     cfg.good_send_rate      <= pwdata[RateW-1:0];
        REG_BAD_RATE:      cfg.bad_send_rate       <= pwdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended.
  always_comb begin
    case (idx)
      REG_RTT_THRESHOLD: prdata = {{(DataW-TimeW){1'b0}}, cfg.rtt_threshold_ms};
      REG_START_PENALTY: prdata = {{(DataW-TimeW){1'b0}}, cfg.start_penalty_ticks};
      REG_MIN_PENALTY:   prdata = {{(DataW-TimeW){1'b0}}, cfg.min_penalty_ticks};
      REG_MAX_PENALTY:   prdata = {{(DataW-TimeW){1'b0}}, cfg.max_penalty_ticks};
      REG_STABLE:        prdata = {{(DataW-TimeW){1'b0}}, cfg.stable_ticks};
      REG_GOOD_RATE:     prdata = {{(DataW-RateW){1'b0}}, cfg.good_send_rate};
      REG_BAD_RATE:      prdata = {{(DataW-RateW){1'b0}}, cfg.bad_send_rate};
      default:           prdata = '0;
    endcase
  end

endmodule

>>> rtl/rttfc_core.sv
// Mode state and next-state logic: one tick or reset event per accepted word.
// Depends on rttfc_pkg for cfg_t, res_t and the saturating increment.
module rttfc_core (
  input  logic                      clk,
  input  logic                      rst,
  input  rttfc_pkg::cfg_t           cfg,
  input  logic                      in_fire,
  input  logic                      kind,
  input  logic [rttfc_pkg::TimeW-1:0] rtt_ms,
  output rttfc_pkg::res_t           res
);
  import rttfc_pkg::*;

  logic             mode_good, mode_good_next;
  logic [TimeW-1:0] penalty_ticks, penalty_ticks_next;
  logic [TimeW-1:0] good_time_ticks, good_time_ticks_next;
  logic [TimeW-1:0] reduction_ticks, reduction_ticks_next;

  logic             rtt_bad;
  logic [TimeW:0]   pen_dbl;
  logic [TimeW-1:0] pen_dbl_clamp;
  logic [TimeW-1:0] pen_half;
  logic [TimeW-1:0] pen_half_clamp;
  logic [TimeW-1:0] good_inc;
  logic [TimeW-1:0] red_inc;
  logic [TimeW-1:0] bad_good_time;

  // Candidate values for the penalty and timers.
  always_comb begin
    rtt_bad        = rtt_ms > cfg.rtt_threshold_ms;
    pen_dbl        = {penalty_ticks, 1'b0};
    pen_dbl_clamp  = (pen_dbl > {1'b0, cfg.max_penalty_ticks}) ?
                     cfg.max_penalty_ticks : pen_dbl[TimeW-1:0];
    pen_half       = penalty_ticks >> 1;
    pen_half_clamp = (pen_half < cfg.min_penalty_ticks) ? cfg.min_penalty_ticks : pen_half;
    good_inc       = sat_inc(good_time_ticks);
    red_inc        = sat_inc(reduction_ticks);
    bad_good_time  = rtt_bad ? '0 : good_inc;
  end

  // Next state for one item.
  always_comb begin
    mode_good_next       = mode_good;
    penalty_ticks_next   = penalty_ticks;
    good_time_ticks_next = good_time_ticks;
    reduction_ticks_next = reduction_ticks;
    if (kind == KIND_RESET) begin
      mode_good_next       = 1'b0;
      penalty_ticks_next   = cfg.start_penalty_ticks;
      good_time_ticks_next = '0;
      reduction_ticks_next = '0;
    end else if (mode_good) begin
      if (rtt_bad) begin
        // Conditions turned bad: drop, and double the penalty after a short run.
        mode_good_next       = 1'b0;
        good_time_ticks_next = '0;
        reduction_ticks_next = '0;
        if (good_time_ticks < cfg.stable_ticks &&
            penalty_ticks < cfg.max_penalty_ticks) begin
          penalty_ticks_next = pen_dbl_clamp;
        end
      end else begin
        // Stable good run: halve the penalty once the reduction timer expires.
        good_time_ticks_next = good_inc;
        reduction_ticks_next = red_inc;
        if (red_inc > cfg.stable_ticks && penalty_ticks > cfg.min_penalty_ticks) begin
          penalty_ticks_next   = pen_half_clamp;
          reduction_ticks_next = '0;
        end
      end
    end else begin
      // Bad mode: upgrade once the good run exceeds the penalty.
      good_time_ticks_next = bad_good_time;
      if (bad_good_time > penalty_ticks) begin
        good_time_ticks_next = '0;
        reduction_ticks_next = '0;
        mode_good_next       = 1'b1;
      end
    end
  end

  // State registers; reset loads the start penalty register's reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_good       <= 1'b0;
      penalty_ticks   <= RST_START_PENALTY;
      good_time_ticks <= '0;
      reduction_ticks <= '0;
    end else if (in_fire) begin
      mode_good       <= mode_good_next;
      penalty_ticks   <= penalty_ticks_next;
      good_time_ticks <= good_time_ticks_next;
      reduction_ticks <= reduction_ticks_next;
    end
  end

  // Result word for this item.
  always_comb begin
    res.good_mode    = mode_good_next;
    res.send_rate    = mode_good_next ? cfg.good_send_rate : cfg.bad_send_rate;
    res.penalty_now  = penalty_ticks_next;
    res.mode_changed = mode_good_next != mode_good;
  end

endmodule

>>> rtl/rttfc_out.sv
// Output register with a skid stage, so the input side keeps flowing while a
// result waits. Depends on rttfc_pkg for res_t.
module rttfc_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  rttfc_pkg::res_t in_res,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rttfc_pkg::res_t out_res
);
  import rttfc_pkg::*;

  logic skid_valid;
  res_t skid_res;

  assign in_ready = !skid_valid;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_fire) begin
        out_res <= in_res;
      end
    end else if (in_fire) begin
      skid_res <= in_res;
    end
  end

endmodule

>>> rtl/rtt_flow_control_mode_top.sv
// Channel   Dir  Contents (lowest bit first)
// s_axis    in   tuser: kind; tdata: rtt_ms[15:0]
// m_axis    out  tdata: good_mode, send_rate[7:0], penalty_now[15:0], mode_changed
// apb       cfg  seven registers at byte addresses 0, 4, ... 24
//
// Each accepted word updates the mode state in the cycle it is accepted; its result
// goes to the output register or skid. One word per cycle while the skid is empty.
// Reset (synchronous, active high) restores register defaults and bad mode.
// An output register plus a skid stage hold up to two results under stall.
// Depends on rttfc_pkg, rttfc_regs, rttfc_core and rttfc_out.
module rtt_flow_control_mode_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [rttfc_pkg::TimeW-1:0] s_tdata,   // rtt_ms
  input  logic                        s_tuser,   // kind
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rttfc_pkg::OutW-1:0]  m_tdata,   // good_mode, send_rate, penalty_now,
                                                 // mode_changed, zero pad
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rttfc_pkg::AddrW-1:0] paddr,
  input  logic [rttfc_pkg::DataW-1:0] pwdata,
  output logic [rttfc_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import rttfc_pkg::*;

  cfg_t cfg;
  res_t core_res;
  res_t out_res;
  logic in_fire;

  assign in_fire = s_tvalid && s_tready;
  assign m_tdata = {{(OutW-$bits(res_t)){1'b0}}, out_res};

  rttfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rttfc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_fire (in_fire),
    .kind    (s_tuser),
    .rtt_ms  (s_tdata),
    .res     (core_res)
  );

  rttfc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_res    (core_res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

endmodule

>>> test/tb_rtt_flow_control_mode_top.sv
// Self-checking testbench for the round-trip-time flow control block.
// A behavioural model of the good/bad mode logic predicts every result word;
// stimulus runs through the stream port and configuration through APB writes.
// Depends on rttfc_pkg and rtt_flow_control_mode_top.
module tb_rtt_flow_control_mode_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rttfc_pkg::*;

  // Register index with no register behind it
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int RUN_LIMIT = 1_000_000;
  localparam int ERR_PRINT_MAX = 40;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TimeW-1:0]    s_tdata = '0;
  logic                s_tuser = KIND_TICK;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutW-1:0]     m_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  // Model state and its copy of the registers
  cfg_t             cfg_model;
  logic             fc_good;
  logic [TimeW-1:0] fc_penalty;
  logic [TimeW-1:0] fc_good_time;
  logic [TimeW-1:0] fc_reduction;

  res_t expected_status[$];
  bit   idle_on = 1'b1;
  int   n_checked = 0;
  int   n_errors = 0;
  int   n_settings = 0;
  int   cycles = 0;

  rtt_flow_control_mode_top uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // RTT samples on either side of the current threshold
  function automatic logic [TimeW-1:0] good_rtt();
    return TimeW'($urandom_range(0, cfg_model.rtt_threshold_ms));
  endfunction

  function automatic logic [TimeW-1:0] bad_rtt();
    if (cfg_model.rtt_threshold_ms == {TimeW{1'b1}}) return {TimeW{1'b1}};
    return TimeW'($urandom_range(cfg_model.rtt_threshold_ms + 1, 65535));
  endfunction

  // Flow control state after power-up or a reset event.
  function automatic void clear_flow_state();
    fc_good      = 1'b0;
    fc_penalty   = cfg_model.start_penalty_ticks;
    fc_good_time = '0;
    fc_reduction = '0;
  endfunction

  // Advances the model by one word and returns the status it reports.
  function automatic res_t step_flow_control(logic kind, logic [TimeW-1:0] rtt);
    res_t           r;
    logic           was_good;
    logic [TimeW:0] doubled;
    logic [TimeW-1:0] halved;
    was_good = fc_good;
    if (kind == KIND_RESET) begin
      clear_flow_state();
    end else if (fc_good) begin
      if (rtt > cfg_model.rtt_threshold_ms) begin
        // Congestion: drop to bad mode, doubling the penalty after a short good run
        fc_good = 1'b0;
        if (fc_good_time < cfg_model.stable_ticks &&
            fc_penalty < cfg_model.max_penalty_ticks) begin
          doubled = {fc_penalty, 1'b0};
          fc_penalty = (doubled > cfg_model.max_penalty_ticks) ?
                       cfg_model.max_penalty_ticks : doubled[TimeW-1:0];
        end
        fc_good_time = '0;
        fc_reduction = '0;
      end else begin
        if (fc_good_time != {TimeW{1'b1}}) fc_good_time = fc_good_time + 1'b1;
        if (fc_reduction != {TimeW{1'b1}}) fc_reduction = fc_reduction + 1'b1;
        // A long stable run earns a halved penalty
        if (fc_reduction > cfg_model.stable_ticks &&
            fc_penalty > cfg_model.min_penalty_ticks) begin
          halved = fc_penalty >> 1;
          fc_penalty = (halved < cfg_model.min_penalty_ticks) ?
                       cfg_model.min_penalty_ticks : halved;
          fc_reduction = '0;
        end
      end
    end else begin
      if (rtt <= cfg_model.rtt_threshold_ms) begin
        if (fc_good_time != {TimeW{1'b1}}) fc_good_time = fc_good_time + 1'b1;
      end else begin
        fc_good_time = '0;
      end
      if (fc_good_time > fc_penalty) begin
        fc_good_time = '0;
        fc_reduction = '0;
        fc_good      = 1'b1;
      end
    end
    r.good_mode    = fc_good;
    r.send_rate    = fc_good ? cfg_model.good_send_rate : cfg_model.bad_send_rate;
    r.penalty_now  = fc_penalty;
    r.mode_changed = (fc_good != was_good);
    return r;
  endfunction

  // Predicts each accepted word and checks each delivered result in order.
  always @(posedge clk) begin : status_check
    res_t got;
    res_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[$bits(res_t)-1:0]);
        n_checked++;
        if (expected_status.size() == 0) begin
          n_errors++;
          if (n_errors <= ERR_PRINT_MAX) $error("result word with nothing expected");
        end else begin
          want = expected_status.pop_front();
          if (got.good_mode !== want.good_mode) begin
            n_errors++;
            if (n_errors <= ERR_PRINT_MAX)
              $error("good_mode: expected %0d, got %0d", want.good_mode, got.good_mode);
          end
          if (got.send_rate !== want.send_rate) begin
            n_errors++;
            if (n_errors <= ERR_PRINT_MAX)
              $error("send_rate: expected %0d, got %0d", want.send_rate, got.send_rate);
          end
          if (got.penalty_now !== want.penalty_now) begin
            n_errors++;
            if (n_errors <= ERR_PRINT_MAX)
              $error("penalty_now: expected %0d, got %0d", want.penalty_now,
                     got.penalty_now);
          end
          if (got.mode_changed !== want.mode_changed) begin
            n_errors++;
            if (n_errors <= ERR_PRINT_MAX)
              $error("mode_changed: expected %0d, got %0d", want.mode_changed,
                     got.mode_changed);
          end
        end
      end
      if (s_tvalid && s_tready) expected_status.push_back(step_flow_control(s_tuser, s_tdata));
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver side: bursts of ready broken by stalls of random length.
  initial begin : drain_ctl
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Sends one word and returns at the edge that accepts it.
  task automatic send_word(input logic kind, input logic [TimeW-1:0] rtt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= rtt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the model follows at the write edge.
  task automatic reg_write(input logic [2:0] idx, input logic [TimeW-1:0] val);
    logic [DataW-1:0] word;
    word = $urandom;
    word[TimeW-1:0] = val;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_RTT_THRESHOLD: cfg_model.rtt_threshold_ms    = val;
      REG_START_PENALTY: cfg_model.start_penalty_ticks = val;
      REG_MIN_PENALTY:   cfg_model.min_penalty_ticks   = val;
      REG_MAX_PENALTY:   cfg_model.max_penalty_ticks   = val;
      REG_STABLE:        cfg_model.stable_ticks        = val;
      REG_GOOD_RATE:     cfg_model.good_send_rate      = val[RateW-1:0];
      REG_BAD_RATE:      cfg_model.bad_send_rate       = val[RateW-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limits(input logic [TimeW-1:0] thr, input logic [TimeW-1:0] start,
                            input logic [TimeW-1:0] lo, input logic [TimeW-1:0] hi,
                            input logic [TimeW-1:0] stable, input logic [RateW-1:0] good,
                            input logic [RateW-1:0] bad);
    reg_write(REG_RTT_THRESHOLD, thr);
    reg_write(REG_START_PENALTY, start);
    reg_write(REG_MIN_PENALTY, lo);
    reg_write(REG_MAX_PENALTY, hi);
    reg_write(REG_STABLE, stable);
    reg_write(REG_GOOD_RATE, {8'h00, good});
    reg_write(REG_BAD_RATE, {8'h00, bad});
    n_settings++;
  endtask

  // Reset-time registers: field extremes, threshold edge, reset event in bad mode.
  task automatic test_reset_defaults();
    send_word(KIND_RESET, 16'hFFFF);
    send_word(KIND_TICK, 16'd0);
    send_word(KIND_TICK, 16'hFFFF);
    send_word(KIND_TICK, RST_RTT_THRESHOLD);
    send_word(KIND_TICK, RST_RTT_THRESHOLD + 16'd1);
    settle();
  endtask

  // Full walk: upgrade, drop with doubling, halving, drop without doubling.
  task automatic test_mode_cycle();
    set_limits(16'd100, 16'd2, 16'd2, 16'd5, 16'd2, 8'd255, 8'd0);
    send_word(KIND_RESET, 16'd0);
    repeat (2) send_word(KIND_TICK, 16'd50);
    send_word(KIND_TICK, 16'd100);
    send_word(KIND_TICK, 16'd101);
    repeat (5) send_word(KIND_TICK, 16'd0);
    repeat (3) send_word(KIND_TICK, 16'd99);
    send_word(KIND_TICK, 16'hFFFF);
    repeat (3) send_word(KIND_TICK, 16'd1);
    send_word(KIND_RESET, 16'd7);
    settle();
  endtask

  // Zero penalty registers, threshold extremes and an unmapped register write.
  task automatic test_odd_limits();
    set_limits(16'd0, 16'd0, 16'd0, 16'd5, 16'd3, 8'h55, 8'hAA);
    send_word(KIND_RESET, 16'd0);
    send_word(KIND_TICK, 16'd0);
    send_word(KIND_TICK, 16'd1);
    settle();
    reg_write(REG_RTT_THRESHOLD, 16'hFFFF);
    reg_write(REG_NONE, 16'h0001);
    send_word(KIND_TICK, 16'hFFFF);
    send_word(KIND_TICK, 16'h8000);
    settle();
  endtask

  // Long good runs in both modes, penalty ceiling and stable length at their maximum.
  task automatic test_long_runs();
    idle_on = 1'b0;
    // Penalty at its ceiling: bad mode holds through a long good run
    set_limits(16'd1000, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 8'hA5, 8'h5A);
    send_word(KIND_RESET, 16'd0);
    repeat (24) send_word(KIND_TICK, good_rtt());
    send_word(KIND_TICK, bad_rtt());
    settle();
    // Long run in good mode below the stable length: no halving, then doubling
    reg_write(REG_START_PENALTY, 16'd3);
    send_word(KIND_RESET, 16'd0);
    repeat (28) send_word(KIND_TICK, good_rtt());
    send_word(KIND_TICK, bad_rtt());
    settle();
    idle_on = 1'b1;
  endtask

  // Random phases: mostly good runs broken by congestion, with noise and resets.
  task automatic test_random_traffic();
    int phase;
    int sent;
    int run;
    int r;
    for (phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: set_limits(16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 8'd0, 8'd255);
        1: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd0);
        default: set_limits(TimeW'($urandom_range(0, 65535)), TimeW'($urandom_range(1, 12)),
                            TimeW'($urandom_range(1, 8)), TimeW'($urandom_range(1, 40)),
                            TimeW'($urandom_range(1, 24)), RateW'($urandom_range(0, 255)),
                            RateW'($urandom_range(0, 255)));
      endcase
      idle_on = (phase % 4) != 3;
      send_word(KIND_RESET, TimeW'($urandom));
      sent = 1;
      while (sent < 100) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_word(KIND_RESET, TimeW'($urandom));
          sent++;
        end else if (r < 12) begin
          send_word(KIND_TICK, TimeW'($urandom));
          sent++;
        end else begin
          run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 20);
          repeat (run) send_word(KIND_TICK, good_rtt());
          sent += run;
          run = $urandom_range(1, 3);
          repeat (run) send_word(KIND_TICK, bad_rtt());
          sent += run;
        end
      end
    end
    idle_on = 1'b1;
    settle();
  endtask

  initial begin
    cfg_model.rtt_threshold_ms    = RST_RTT_THRESHOLD;
    cfg_model.start_penalty_ticks = RST_START_PENALTY;
    cfg_model.min_penalty_ticks   = RST_MIN_PENALTY;
    cfg_model.max_penalty_ticks   = RST_MAX_PENALTY;
    cfg_model.stable_ticks        = RST_STABLE;
    cfg_model.good_send_rate      = RST_GOOD_RATE;
    cfg_model.bad_send_rate       = RST_BAD_RATE;
    clear_flow_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_mode_cycle();
    test_odd_limits();
    test_long_runs();
    test_random_traffic();

    if (expected_status.size() != 0) begin
      n_errors++;
      $error("%0d expected words never arrived", expected_status.size());
    end
    $display("Checked %0d result words over %0d register settings, with %0d mismatches.",
             n_checked, n_settings, n_errors);
    $display("Covered mode changes, penalty doubling and halving, zero and extreme limits,");
    $display("long good runs in both modes, and random traffic under stalls.");
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
